>>> hdl/dfct_pkg.sv
// ----------------------------------------------------------------------------
// dfct_pkg
// Shared constants and types of the fragment count table.
// ----------------------------------------------------------------------------
package dfct_pkg;
	localparam int TABLE_ENTRIES = 1024;
	localparam int WAYS = 4;
	localparam int FINGERPRINT_BYTES = 32;
	localparam int SETS = TABLE_ENTRIES / WAYS;
	localparam int SET_BITS = $clog2(SETS);
	localparam int ENTRY_BITS = $clog2(TABLE_ENTRIES);
	localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int KEY_W = 256;
	localparam int LEN_W = 40;
	localparam int CNT_W = 32;
	localparam int SUM_W = 64;
	localparam int ENTRY_W = KEY_W + LEN_W + CNT_W;
	localparam logic [4:0] SHIFT_MAX = 5'd20;
	localparam logic [4:0] PAGE_SHIFT_RESET = 5'd12;

	localparam logic [1:0] REG_PAGE_SHIFT = 2'd0;

	localparam logic [1:0] ST_NEW = 2'd0;
	localparam logic [1:0] ST_DUP = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic key_unused_pad;
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] len;
		logic [CNT_W-1:0] cnt;
	} entry_pad_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] len;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic update;
		logic out_load;
	} dp_cmd_t;

	function automatic logic [KEY_W-1:0] key_mask();
		logic [KEY_W-1:0] m;
		m = '0;
		for (int i = 0; i < KEY_W / 8; i++)
			if (i < FINGERPRINT_BYTES)
				m[KEY_W-1-8*i -: 8] = 8'hff;
		return m;
	endfunction
endpackage

>>> hdl/dfct_if.sv
// ----------------------------------------------------------------------------
// dfct_frag_if, dfct_res_if
// Valid/ready channels for fragments and results.
// ----------------------------------------------------------------------------
interface dfct_frag_if;
	logic valid;
	logic ready;
	logic [63:0] fingerprint_w0;
	logic [63:0] fingerprint_w1;
	logic [63:0] fingerprint_w2;
	logic [63:0] fingerprint_w3;
	logic [39:0] frag_len;
	modport source(output valid, fingerprint_w0, fingerprint_w1, fingerprint_w2,
		fingerprint_w3, frag_len, input ready);
	modport sink(input valid, fingerprint_w0, fingerprint_w1, fingerprint_w2,
		fingerprint_w3, frag_len, output ready);
endinterface

interface dfct_res_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [31:0] entry_count;
	logic [63:0] total_frags;
	logic [63:0] unique_frags;
	logic [63:0] total_bytes;
	logic [63:0] uniq_bytes;
	logic [63:0] total_page_bytes;
	logic [63:0] unique_page_bytes;
	modport source(output valid, status, entry_count, total_frags, unique_frags,
		total_bytes, uniq_bytes, total_page_bytes, unique_page_bytes, input ready);
	modport sink(input valid, status, entry_count, total_frags, unique_frags,
		total_bytes, uniq_bytes, total_page_bytes, unique_page_bytes, output ready);
endinterface

>>> hdl/dedup_fragment_count_table.sv
// A fragment that is accepted is read from each way's RAM and moves the controller to its
// update state, at whose end its status and count are registered as the result word.
// A new fragment is taken only in the idle state, since one RAM port per way is read and then
// written; a result word that is not taken holds off the next fragment.
// Reset: asynchronous, active low; totals clear and page_shift returns to 12 at once, then
// a clearing pass over all 256 sets zeroes the valid bits before the first fragment is taken.
// ----------------------------------------------------------------------------
// dedup_fragment_count_table
// Set-associative fingerprint table with occurrence counts and running totals.
// ----------------------------------------------------------------------------
module dedup_fragment_count_table import dfct_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	dfct_frag_if.sink    frag,
	dfct_res_if.source   res
);
	logic [4:0] page_shift_q;
	dp_cmd_t cmd;
	logic clr_last;
	logic [SUM_W-1:0] sums [6];
	logic [KEY_W-1:0] key;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_PAGE_SHIFT) ? {27'd0, page_shift_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			page_shift_q <= PAGE_SHIFT_RESET;
		else if (psel && penable && pwrite && paddr == REG_PAGE_SHIFT)
			page_shift_q <= pwdata[4:0];
	end

	assign key = {frag.fingerprint_w0, frag.fingerprint_w1, frag.fingerprint_w2,
		frag.fingerprint_w3} & key_mask();

	dfct_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(frag.valid), .in_ready(frag.ready),
		.out_valid(res.valid), .out_ready(res.ready), .clr_last(clr_last), .cmd(cmd));

	dfct_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .page_shift(page_shift_q),
		.key_in(key), .len_in(frag.frag_len), .clr_last(clr_last), .status(res.status),
		.entry_count(res.entry_count), .sums(sums));

	assign res.total_frags = sums[0];
	assign res.unique_frags = sums[1];
	assign res.total_bytes = sums[2];
	assign res.uniq_bytes = sums[3];
	assign res.total_page_bytes = sums[4];
	assign res.unique_page_bytes = sums[5];
endmodule

>>> hdl/dfct_ram.sv
// ----------------------------------------------------------------------------
// dfct_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module dfct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

>>> hdl/dfct_ctrl.sv
// ----------------------------------------------------------------------------
// dfct_ctrl
// Controller: clearing pass, read cycle, update cycle, result hand-off.
// ----------------------------------------------------------------------------
module dfct_ctrl import dfct_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  logic    clr_last,
	output dp_cmd_t cmd
);
	localparam logic [1:0] S_CLR = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_UPD = 2'd2;
	logic [1:0] state_q;
	logic ovalid_q;

	assign in_ready = (state_q == S_IDLE) && (!ovalid_q || out_ready);
	assign out_valid = ovalid_q;
	assign cmd.clear = state_q == S_CLR;
	assign cmd.load = in_valid && in_ready;
	assign cmd.update = state_q == S_UPD;
	assign cmd.out_load = state_q == S_UPD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ovalid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: if (clr_last) state_q <= S_IDLE;
				S_IDLE: if (cmd.load) state_q <= S_UPD;
				S_UPD: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_UPD)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_upd_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_UPD) else $error("no update after load");
	a_no_load_in_upd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> !in_ready) else $error("accept during update");
	a_valid_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |=> ovalid_q) else $error("result lost");
	a_no_load_in_clr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !in_ready) else $error("accept during clearing");
`endif
endmodule

>>> hdl/dfct_dp.sv
// ----------------------------------------------------------------------------
// dfct_dp
// Datapath: set memory per way, tag compare, count update and totals.
// ----------------------------------------------------------------------------
module dfct_dp import dfct_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  logic [4:0]       page_shift,
	input  logic [KEY_W-1:0] key_in,
	input  logic [LEN_W-1:0] len_in,
	output logic             clr_last,
	output logic [1:0]       status,
	output logic [CNT_W-1:0] entry_count,
	output logic [SUM_W-1:0] sums [6]
);
	logic [KEY_W-1:0] key_q;
	logic [LEN_W-1:0] len_q;
	logic [SET_BITS-1:0] set_q;
	logic [SET_BITS-1:0] clr_q;
	logic [SET_BITS-1:0] set_d;
	logic [SET_BITS-1:0] ram_addr;
	logic [SET_BITS-1:0] vaddr;
	logic vwe;
	logic [WAYS-1:0] vwdata;
	logic [WAYS-1:0] vset;
	entry_t rd [WAYS];
	logic [WAYS-1:0] we;
	entry_t wr;
	logic [SUM_W-1:0] sum_q [6];
	logic [1:0] st;
	logic [CNT_W-1:0] cnt;
	logic hit, fr;
	logic [WAY_BITS-1:0] hw, fw;
	logic [4:0] sh;
	logic [SUM_W-1:0] pb, len64, page;

	assign set_d = key_in[KEY_W-1 -: SET_BITS];
	assign ram_addr = cmd.load ? set_d : set_q;
	assign vaddr = cmd.clear ? clr_q : ram_addr;
	assign clr_last = clr_q == SET_BITS'(SETS - 1);

	for (genvar g = 0; g < WAYS; g++) begin : g_way
		dfct_ram #(.WIDTH(ENTRY_W), .DEPTH(SETS)) u_ram (
			.clk(clk), .we(we[g]), .addr(ram_addr),
			.wdata(wr), .rdata(rd[g]));
	end

	dfct_ram #(.WIDTH(WAYS), .DEPTH(SETS)) u_vram (
		.clk(clk), .we(vwe), .addr(vaddr), .wdata(vwdata), .rdata(vset));

	always_comb begin
		hit = 1'b0; fr = 1'b0; hw = '0; fw = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (vset[i]) begin
				if (!hit && rd[i].key == key_q) begin
					hit = 1'b1; hw = WAY_BITS'(i);
				end
			end else if (!fr) begin
				fr = 1'b1; fw = WAY_BITS'(i);
			end
		end
		we = '0;
		wr.key = key_q; wr.len = len_q; wr.cnt = CNT_W'(1);
		cnt = '0;
		if (hit) begin
			if (rd[hw].len != len_q) begin
				st = ST_MISMATCH; cnt = rd[hw].cnt;
			end else begin
				st = ST_DUP;
				cnt = (rd[hw].cnt == '1) ? rd[hw].cnt : rd[hw].cnt + 1'b1;
				wr.cnt = cnt;
				we[hw] = cmd.update;
			end
		end else if (fr) begin
			st = ST_NEW; cnt = CNT_W'(1); we[fw] = cmd.update;
		end else
			st = ST_FULL;
		vwe = cmd.clear || (cmd.update && st == ST_NEW);
		vwdata = cmd.clear ? '0 : (vset | (WAYS'(1) << fw));
		sh = (page_shift > SHIFT_MAX) ? SHIFT_MAX : page_shift;
		len64 = {{(SUM_W-LEN_W){1'b0}}, len_q};
		page = SUM_W'(1) << sh;
		pb = ((len64 + page - 1'b1) >> sh) << sh;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key_in;
			len_q <= len_in;
			set_q <= set_d;
		end
		if (cmd.out_load) begin
			status <= st;
			entry_count <= cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) sum_q[k] <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (cmd.update && (st == ST_NEW || st == ST_DUP)) begin
				sum_q[0] <= sum_q[0] + 1'b1;
				sum_q[2] <= sum_q[2] + len64;
				sum_q[4] <= sum_q[4] + pb;
				if (st == ST_NEW) begin
					sum_q[1] <= sum_q[1] + 1'b1;
					sum_q[3] <= sum_q[3] + len64;
					sum_q[5] <= sum_q[5] + pb;
				end
			end
		end
	end

	assign sums = sum_q;

`ifndef SYNTHESIS
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(we)) else $error("two ways written");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		st == ST_FULL |-> we == '0) else $error("write on full set");
	a_write_only_upd: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.update |-> we == '0) else $error("stray write");
`endif
endmodule
